### hw/rtl/assert_macros.svh
// Assertion macros used by the multiset count table RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising edge while reset is low.
`define MCT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
// The expression must never be true while reset is low.
`define MCT_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define MCT_ASSERT(label, clk, rst, prop)
`define MCT_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### hw/rtl/mct_pkg.sv
// Shared types, codes and defaults of the multiset count table.
// Used by every module of the block; depends on nothing.
package mct_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
  localparam int unsigned DEFAULT_COUNT_BITS  = 16;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 16;
  localparam int unsigned DIST_OUT_W = 5;
  localparam int unsigned TOTAL_W    = 20;
  // Slot index width that covers the deepest supported table (1024 entries).
  localparam int unsigned SLOT_W_MAX = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

  // A classified item, as handed from the front to the back.
  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [VALUE_W-1:0]    value;
    logic                  hit;
    logic                  full;
    logic [SLOT_W_MAX-1:0] slot;
    logic [VALUE_W-1:0]    last_value;
  } cmd_t;

  // A write into the value table, issued by the back.
  typedef struct packed {
    logic                  en;
    logic [SLOT_W_MAX-1:0] idx;
    logic [VALUE_W-1:0]    data;
  } tbl_wr_t;

endpackage

### hw/rtl/mct_front.sv
// Front of the multiset count table: accepts items, holds the value table
// and classifies each item by a parallel compare. Depends on mct_pkg.
module mct_front #(
  parameter int unsigned TABLE_DEPTH = mct_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned DIST_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mct_pkg::OP_W-1:0]    op,
  input  logic [mct_pkg::VALUE_W-1:0] value,
  input  logic                        finish,
  input  mct_pkg::tbl_wr_t            wr,
  input  logic [DIST_W-1:0]           distinct,
  output logic                        busy,
  output logic                        push,
  output mct_pkg::cmd_t               cmd
);
  import mct_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  last;
  logic [DIST_W-1:0] last_wide;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      value_mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

  // Only slots below the distinct count are live and take part.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (DIST_W'(i) < distinct) && (value_mem[i] == value);
    end
  end

  // The lowest matching slot wins.
  always_comb begin
    slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        slot = IDX_W'(i);
      end
    end
  end

  assign last_wide = distinct - 1'b1;
  assign last      = last_wide[IDX_W-1:0];
  assign push      = start & ~busy;

  always_comb begin
    cmd.op         = op;
    cmd.value      = value;
    cmd.hit        = |match;
    cmd.full       = (distinct == DIST_W'(TABLE_DEPTH));
    cmd.slot       = SLOT_W_MAX'(slot);
    cmd.last_value = value_mem[last];
  end

  // One item at a time: busy from acceptance until its result is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (push) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

endmodule

### hw/rtl/mct_queue.sv
// Short queue of classified items between the front and the back.
// Depends on mct_pkg for the item type and the queue depth.
module mct_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mct_pkg::cmd_t din,
  input  logic          pop,
  output mct_pkg::cmd_t head,
  output logic          empty
);
  import mct_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (fill == '0);

endmodule

### hw/rtl/mct_back.sv
// Back of the multiset count table: executes classified items against the
// count memory, keeps the totals and issues results. Depends on mct_pkg.
`include "assert_macros.svh"
module mct_back #(
  parameter int unsigned TABLE_DEPTH = mct_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned COUNT_BITS  = mct_pkg::DEFAULT_COUNT_BITS,
  parameter int unsigned DIST_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mct_pkg::cmd_t                  head,
  input  logic                           empty,
  output logic                           pop,
  output mct_pkg::tbl_wr_t               wr,
  output logic [DIST_W-1:0]              distinct,
  output logic                           finish,
  output logic                           done,
  output logic [mct_pkg::STATUS_W-1:0]   status,
  output logic [mct_pkg::OCC_W-1:0]      occurrences,
  output logic [mct_pkg::DIST_OUT_W-1:0] distinct_entries,
  output logic [mct_pkg::TOTAL_W-1:0]    total_elements
);
  import mct_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MOVE = 3'b100
  } state_t;

  state_t state, state_next;
  cmd_t   cur;

  logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  cwr_en;
  logic [IDX_W-1:0]      cwr_addr;
  logic [COUNT_BITS-1:0] cwr_data;

  logic [DIST_W-1:0]     distinct_next;
  logic [DIST_W-1:0]     last_wide;
  logic [TOTAL_W-1:0]    total, total_next;
  logic [STATUS_W-1:0]   res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [31:0]           res_count_wide;
  logic [31:0]           distinct_wide;

  assign last_wide = distinct - 1'b1;

  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    finish        = 1'b0;
    rd_addr       = head.slot[IDX_W-1:0];
    cwr_en        = 1'b0;
    cwr_addr      = cur.slot[IDX_W-1:0];
    cwr_data      = '0;
    wr            = '0;
    distinct_next = distinct;
    total_next    = total;
    res_status    = STATUS_OK;
    res_count     = '0;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.hit) begin
            state_next = S_READ;
          end else begin
            finish = 1'b1;
            if (head.op == OP_ADD && !head.full) begin
              // New value goes into the first free slot with a count of one.
              cwr_en        = 1'b1;
              cwr_addr      = distinct[IDX_W-1:0];
              cwr_data      = COUNT_ONE;
              wr.en         = 1'b1;
              wr.idx        = SLOT_W_MAX'(distinct[IDX_W-1:0]);
              wr.data       = head.value;
              distinct_next = distinct + 1'b1;
              total_next    = total + 1'b1;
              res_count     = COUNT_ONE;
            end else if (head.op == OP_ADD) begin
              res_status = STATUS_FULL;
            end else begin
              res_status = STATUS_ABSENT;
            end
          end
        end
      end
      S_READ: begin
        if (cur.op == OP_ADD) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (rd_data == COUNT_MAX) begin
            res_status = STATUS_SATURATED;
            res_count  = rd_data;
          end else begin
            cwr_en     = 1'b1;
            cwr_data   = rd_data + 1'b1;
            total_next = total + 1'b1;
            res_count  = rd_data + 1'b1;
          end
        end else if (cur.op == OP_REMOVE) begin
          if (rd_data > COUNT_ONE) begin
            finish     = 1'b1;
            state_next = S_IDLE;
            cwr_en     = 1'b1;
            cwr_data   = rd_data - 1'b1;
            total_next = total - 1'b1;
            res_count  = rd_data - 1'b1;
          end else begin
            // Last occurrence: fetch the count of the last live slot.
            rd_addr    = last_wide[IDX_W-1:0];
            state_next = S_MOVE;
          end
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
          res_count  = rd_data;
        end
      end
      S_MOVE: begin
        // The last live entry fills the freed slot and the table shrinks.
        finish        = 1'b1;
        state_next    = S_IDLE;
        cwr_en        = 1'b1;
        cwr_data      = rd_data;
        wr.en         = 1'b1;
        wr.idx        = cur.slot;
        wr.data       = cur.last_value;
        distinct_next = distinct - 1'b1;
        total_next    = total - 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cwr_en) begin
      count_mem[cwr_addr] <= cwr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= count_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      distinct <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      distinct <= distinct_next;
      total    <= total_next;
      done     <= finish;
    end
  end

  assign res_count_wide = 32'(res_count);
  assign distinct_wide  = 32'(distinct_next);

  always_ff @(posedge clk) begin
    if (finish) begin
      status           <= res_status;
      occurrences      <= res_count_wide[OCC_W-1:0];
      distinct_entries <= distinct_wide[DIST_OUT_W-1:0];
      total_elements   <= total_next;
    end
  end

  `MCT_ASSERT(a_done_single, clk, rst, done |=> !done)
  `MCT_ASSERT_NEVER(a_distinct_bound, clk, rst, distinct > DIST_W'(TABLE_DEPTH))
  `MCT_ASSERT(a_move_is_remove, clk, rst, (state == S_MOVE) |-> (cur.op == OP_REMOVE && cur.hit))
  `MCT_ASSERT(a_full_table, clk, rst, (done && status == STATUS_FULL) |-> (occurrences == '0 && distinct == DIST_W'(TABLE_DEPTH)))

endmodule

### hw/rtl/multiset_count_table.sv
// Top level of the multiset count table: front, queue and back wired up.
// Depends on mct_pkg, mct_front, mct_queue and mct_back.
//
// The block keeps a bag of 32-bit values as a table of up to TABLE_DEPTH
// distinct values, each with a COUNT_BITS-wide occurrence count. An item is
// taken at a rising edge where start is high and busy is low; it carries an
// operation (add, remove, or query; the unused code acts as a query) and a
// value. Every item yields exactly one result, shown for exactly one cycle
// with done high, and there is no way to hold it off: the receiver must take
// it in that cycle. The result carries a status, the value's count after the
// operation, the number of distinct values and the bag size (low 20 bits).
// Only one item is in flight: busy rises at acceptance and falls in the cycle
// in which its result is shown, so a new item may be started in that same
// cycle. An item whose value is not in the table is finished when the back
// takes it from the queue; one that hits first has its count read from the
// count memory; removing the last occurrence of a value also reads the count
// of the last live slot as a second step before it is moved into the freed
// slot. All live values are compared in parallel when the item is taken. A
// full table or a count at its maximum is reported in the status and leaves
// the table unchanged. After reset the table is empty at once; no clearing
// pass is needed.
module multiset_count_table #(
  parameter int unsigned TABLE_DEPTH = mct_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned COUNT_BITS  = mct_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mct_pkg::OP_W-1:0]       op,
  input  logic [mct_pkg::VALUE_W-1:0]    value,
  output logic                           busy,
  output logic                           done,
  output logic [mct_pkg::STATUS_W-1:0]   status,
  output logic [mct_pkg::OCC_W-1:0]      occurrences,
  output logic [mct_pkg::DIST_OUT_W-1:0] distinct_entries,
  output logic [mct_pkg::TOTAL_W-1:0]    total_elements
);
  import mct_pkg::*;

  localparam int unsigned DIST_W = $clog2(TABLE_DEPTH + 1);

  logic              push;
  logic              pop;
  logic              empty;
  logic              finish;
  cmd_t              cmd;
  cmd_t              head;
  tbl_wr_t           wr;
  logic [DIST_W-1:0] distinct;

  // The front compares the incoming value against all live entries and
  // queues the classified item in the cycle it is accepted.
  mct_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DIST_W     (DIST_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .op      (op),
    .value   (value),
    .finish  (finish),
    .wr      (wr),
    .distinct(distinct),
    .busy    (busy),
    .push    (push),
    .cmd     (cmd)
  );

  mct_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd),
    .pop  (pop),
    .head (head),
    .empty(empty)
  );

  // The back owns the counts and totals, and writes moved or new values
  // back into the front's value table.
  mct_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .DIST_W     (DIST_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .wr              (wr),
    .distinct        (distinct),
    .finish          (finish),
    .done            (done),
    .status          (status),
    .occurrences     (occurrences),
    .distinct_entries(distinct_entries),
    .total_elements  (total_elements)
  );

endmodule
